>>> sv/earbc_pkg.sv
// ----------------------------------------------------------------------------
// earbc_pkg
// Shared constants and types for the eye aspect ratio blink counter.
// ----------------------------------------------------------------------------
package earbc_pkg;

  localparam int CoordBits     = 12;
  localparam int RatioFracBits = 14;
  localparam int DistFracBits  = 15;
  localparam int PointBits     = 24;
  localparam int NumPoints     = 6;

  // squared distance, shifted square and root widths
  localparam int D2Bits    = 2 * CoordBits + 1;
  localparam int RadBits   = D2Bits + 2 * DistFracBits;
  localparam int RootBits  = (RadBits + 1) / 2;
  localparam int SqrtSteps = (RadBits + 1) / 2;
  localparam int SumBits   = RootBits + 1;
  localparam int NumBits   = SumBits + RatioFracBits;
  localparam int DenBits   = RootBits + 1;
  localparam int RatioBits = 16;
  localparam int QuoBits   = NumBits;

  localparam int CfgIdxBits  = 1;
  localparam int CfgDataBits = 16;
  localparam logic [CfgIdxBits-1:0] CfgEarThreshold   = 1'b0;
  localparam logic [CfgIdxBits-1:0] CfgMinClosedFrames = 1'b1;

  localparam logic [RatioBits-1:0] RatioMax =
      ((4 << RatioFracBits) - 1) > 65535 ? 16'hFFFF
                                         : RatioBits'((4 << RatioFracBits) - 1);
  localparam logic [15:0] RunMax = 16'hFFFF;

  typedef logic [PointBits-1:0] point_t;

  typedef struct packed {
    point_t p0, p1, p2, p3, p4, p5;
  } eye_t;

  // datapath commands
  typedef struct packed {
    logic       load;      // capture input item
    logic       dist_init; // start a root on distance index
    logic [1:0] dist_sel;  // 0: p1p5, 1: p2p4, 2: p0p3
    logic       eye_sel;   // 0 left, 1 right
    logic       sqrt_step;
    logic       dist_store;
    logic       div_init;
    logic       div_step;
    logic       ratio_store;
    logic       finish;    // update run and blink count
  } earbc_cmd_t;

  typedef struct packed {
    logic last_sqrt;
    logic last_div;
  } earbc_sts_t;

endpackage

>>> sv/earbc_if.sv
// ----------------------------------------------------------------------------
// earbc_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface earbc_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/eye_aspect_ratio_blink_counter.sv
// ----------------------------------------------------------------------------
// eye_aspect_ratio_blink_counter
// Eye aspect ratio per face, averaged over both eyes, with blink counting.
// ----------------------------------------------------------------------------
// channel | direction | payload
// in_     | sink      | left_p0..left_p5, right_p0..right_p5 (24 bits each)
// out_    | source    | ear_avg, blink_total, blink_seen, closed_run
// cfg_    | write     | index 0 ear_threshold, index 1 min_closed_frames
//
// each item runs through the one-bit-per-cycle square root and divider,
// shared by six roots and two divisions, then the output handshake.
// reset is synchronous; one item is in flight at a time,
// a stalled result holds the block until it is taken.
module eye_aspect_ratio_blink_counter (
  input  logic clk,
  input  logic rst_n,
  earbc_if.sink   in_ch,
  earbc_if.source out_ch,
  input  logic                                   cfg_we,
  input  logic [earbc_pkg::CfgIdxBits-1:0]       cfg_idx,
  input  logic [earbc_pkg::CfgDataBits-1:0]      cfg_data
);

  earbc_pkg::earbc_cmd_t cmd;
  earbc_pkg::earbc_sts_t sts;

  earbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  earbc_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .left_in     (in_ch.data.left),
    .right_in    (in_ch.data.right),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_data    (cfg_data),
    .ear_avg     (out_ch.data.ear_avg),
    .blink_total (out_ch.data.blink_total),
    .blink_seen  (out_ch.data.blink_seen),
    .closed_run  (out_ch.data.closed_run)
  );

endmodule

>>> sv/earbc_ctrl.sv
// ----------------------------------------------------------------------------
// earbc_ctrl
// Sequencer: for each eye three roots then one division, then the update.
// ----------------------------------------------------------------------------
module earbc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output earbc_pkg::earbc_cmd_t cmd,
  input  earbc_pkg::earbc_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_SQRT, S_DIV_INIT, S_DIV, S_FIN, S_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] dist_r, dist_nxt;
  logic       eye_r, eye_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    dist_nxt  = dist_r;
    eye_nxt   = eye_r;
    cmd       = '0;
    cmd.dist_sel = dist_r;
    cmd.eye_sel  = eye_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          dist_nxt  = 2'd0;
          eye_nxt   = 1'b0;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.dist_init = 1'b1;
        state_nxt     = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.last_sqrt) begin
          cmd.dist_store = 1'b1;
          if (dist_r == 2'd2) begin
            state_nxt = S_DIV_INIT;
          end else begin
            dist_nxt  = dist_r + 2'd1;
            state_nxt = S_INIT;
          end
        end
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.last_div) begin
          cmd.ratio_store = 1'b1;
          if (eye_r) begin
            state_nxt = S_FIN;
          end else begin
            eye_nxt   = 1'b1;
            dist_nxt  = 2'd0;
            state_nxt = S_INIT;
          end
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dist_r  <= 2'd0;
      eye_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dist_r  <= dist_nxt;
      eye_r   <= eye_nxt;
    end
  end

endmodule

>>> sv/earbc_dp.sv
// ----------------------------------------------------------------------------
// earbc_dp
// Datapath: bit-serial square root, restoring divider, run and blink state.
// ----------------------------------------------------------------------------
module earbc_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  earbc_pkg::earbc_cmd_t cmd,
  output earbc_pkg::earbc_sts_t sts,
  input  earbc_pkg::eye_t       left_in,
  input  earbc_pkg::eye_t       right_in,
  input  logic                  cfg_we,
  input  logic [earbc_pkg::CfgIdxBits-1:0]  cfg_idx,
  input  logic [earbc_pkg::CfgDataBits-1:0] cfg_data,
  output logic [15:0]           ear_avg,
  output logic [31:0]           blink_total,
  output logic                  blink_seen,
  output logic [15:0]           closed_run
);

  localparam int CB = earbc_pkg::CoordBits;
  // radicand padded to an even width, two bits consumed per root step
  localparam int RB = 2 * earbc_pkg::SqrtSteps;
  localparam int QB = earbc_pkg::RootBits;
  localparam int NB = earbc_pkg::NumBits;
  localparam int DB = earbc_pkg::DenBits;
  localparam int StepBits = $clog2(earbc_pkg::SqrtSteps + 1);
  localparam int DivBits  = $clog2(NB + 1);

  earbc_pkg::eye_t left_r, right_r, eye;
  logic [15:0] thr_r;
  logic [7:0]  minc_r;
  logic [15:0] run_r;
  logic [31:0] blink_r;
  logic        seen_r;
  logic [15:0] avg_r;

  // root state: remainder, root, radicand shift
  logic [RB-1:0] rad_r;
  logic [QB+1:0] rem_r;
  logic [QB-1:0] root_r;
  logic [StepBits-1:0] sstep_r;
  logic [QB-1:0] da_r, db_r, dc_r;

  // divider state
  logic [NB-1:0] quo_r;
  logic [DB:0]   drem_r;
  logic [DB-1:0] den_r;
  logic [DivBits-1:0] dstep_r;
  logic [15:0] rl_r;

  // operand selection
  earbc_pkg::point_t pa, pb;
  logic [CB-1:0] ax, ay, bx, by, dx, dy;
  logic [2*CB-1:0] dx2, dy2;
  logic [earbc_pkg::D2Bits-1:0] d2;

  assign eye = cmd.eye_sel ? right_r : left_r;
  always_comb begin
    unique case (cmd.dist_sel)
      2'd0:    begin pa = eye.p1; pb = eye.p5; end
      2'd1:    begin pa = eye.p2; pb = eye.p4; end
      default: begin pa = eye.p0; pb = eye.p3; end
    endcase
    ax = pa[2*CB-1:CB];
    ay = pa[CB-1:0];
    bx = pb[2*CB-1:CB];
    by = pb[CB-1:0];
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    dx2 = dx * dx;
    dy2 = dy * dy;
    d2 = {1'b0, dx2} + {1'b0, dy2};
  end

  // one root digit per step
  logic [QB+1:0] trial, rem_sh;
  always_comb begin
    rem_sh = {rem_r[QB-1:0], rad_r[RB-1 -: 2]};
    trial  = {root_r, 2'b01};
  end

  assign sts.last_sqrt = (sstep_r == StepBits'(earbc_pkg::SqrtSteps - 1));
  assign sts.last_div  = (dstep_r == DivBits'(NB - 1));

  // divider step
  logic [NB-1:0] num;
  logic [DB:0]   drem_sh;
  assign num     = NB'({1'b0, da_r} + {1'b0, db_r}) << earbc_pkg::RatioFracBits;
  assign drem_sh = {drem_r[DB-1:0], quo_r[NB-1]};

  logic [NB-1:0] quo_fin;
  logic [15:0]   ratio_sat;
  always_comb begin
    quo_fin = {quo_r[NB-2:0], (drem_sh >= {1'b0, den_r})};
    if (dc_r == '0 || quo_fin > NB'(earbc_pkg::RatioMax)) begin
      ratio_sat = earbc_pkg::RatioMax;
    end else begin
      ratio_sat = quo_fin[15:0];
    end
  end

  logic [16:0] avg_sum;
  logic [15:0] avg_w;
  assign avg_sum = {1'b0, rl_r} + {1'b0, ratio_sat};
  assign avg_w   = avg_sum[16:1];

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= 16'd3277;
      minc_r <= 8'd3;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        earbc_pkg::CfgEarThreshold:    thr_r  <= cfg_data;
        earbc_pkg::CfgMinClosedFrames: minc_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // payload and arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      left_r  <= left_in;
      right_r <= right_in;
    end
    if (cmd.dist_init) begin
      rad_r   <= RB'(d2) << (2 * earbc_pkg::DistFracBits);
      rem_r   <= '0;
      root_r  <= '0;
      sstep_r <= '0;
    end else if (cmd.sqrt_step) begin
      rad_r   <= rad_r << 2;
      sstep_r <= sstep_r + StepBits'(1);
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[QB-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[QB-2:0], 1'b0};
      end
    end
    if (cmd.dist_store) begin
      unique case (cmd.dist_sel)
        2'd0:    da_r <= (rem_sh >= trial) ? {root_r[QB-2:0], 1'b1} : {root_r[QB-2:0], 1'b0};
        2'd1:    db_r <= (rem_sh >= trial) ? {root_r[QB-2:0], 1'b1} : {root_r[QB-2:0], 1'b0};
        default: dc_r <= (rem_sh >= trial) ? {root_r[QB-2:0], 1'b1} : {root_r[QB-2:0], 1'b0};
      endcase
    end
    if (cmd.div_init) begin
      quo_r   <= num;
      drem_r  <= '0;
      den_r   <= {dc_r, 1'b0};
      dstep_r <= '0;
    end else if (cmd.div_step) begin
      dstep_r <= dstep_r + DivBits'(1);
      quo_r   <= quo_fin;
      if (drem_sh >= {1'b0, den_r}) begin
        drem_r <= drem_sh - {1'b0, den_r};
      end else begin
        drem_r <= drem_sh;
      end
    end
    if (cmd.ratio_store && !cmd.eye_sel) begin
      rl_r <= ratio_sat;
    end
    if (cmd.ratio_store && cmd.eye_sel) begin
      avg_r <= avg_w;
    end
  end

  // run and blink state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= '0;
      blink_r <= '0;
      seen_r  <= 1'b0;
    end else if (cmd.finish) begin
      if (avg_r < thr_r) begin
        seen_r <= 1'b0;
        if (run_r != earbc_pkg::RunMax) begin
          run_r <= run_r + 16'd1;
        end
      end else begin
        seen_r <= (run_r >= {8'd0, minc_r});
        if (run_r >= {8'd0, minc_r}) begin
          blink_r <= blink_r + 32'd1;
        end
        run_r <= '0;
      end
    end
  end

  assign ear_avg     = avg_r;
  assign blink_total = blink_r;
  assign blink_seen  = seen_r;
  assign closed_run  = run_r;

endmodule

>>> sv/earbc_check.sv
// ----------------------------------------------------------------------------
// earbc_check
// Port-level checks for the blink counter, bound to the top level.
// ----------------------------------------------------------------------------
module earbc_check (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic blink_seen,
  input logic [31:0] blink_total,
  input logic [15:0] closed_run
);

  // no new request while a result is pending
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken with result pending");

  // a counted blink closes the run
  a_blink_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && blink_seen |-> closed_run == 16'd0)
    else $error("blink with open run");

  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(blink_total))
    else $error("result dropped under stall");

  // accept leads to busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("double accept");

endmodule

bind eye_aspect_ratio_blink_counter earbc_check u_check (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .blink_seen  (out_ch.data.blink_seen),
  .blink_total (out_ch.data.blink_total),
  .closed_run  (out_ch.data.closed_run)
);
